>>> hdl/dspb_pkg.sv
package dspb_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 6;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [DATA_W-1:0]    END_MARK  = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0]   RST_LIMIT = 31'd1000;
    localparam int                   RST_CAP   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_USED_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT   = 1'd1;

    typedef enum logic {
        S_LOAD,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic push;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic end_mark;
        logic met;
        logic meets_after;
        logic empty;
        logic last;
    } t_status;

endpackage

>>> hdl/dspb_ctrl.sv
module dspb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dspb_pkg::t_status i_status,
    output dspb_pkg::t_cmd    o_cmd
);

    dspb_pkg::t_state r_state;
    dspb_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dspb_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.push = 1'b0;
        o_cmd.step = 1'b0;
        busy       = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            dspb_pkg::S_LOAD: begin
                accept     = start;
                o_cmd.push = accept && !i_status.end_mark && !i_status.met;
                if (accept && (i_status.end_mark || i_status.met || i_status.meets_after)) begin
                    n_state = dspb_pkg::S_DRAIN;
                end
            end
            dspb_pkg::S_DRAIN: begin
                busy = 1'b1;
                if (i_status.empty) begin
                    n_state = dspb_pkg::S_LOAD;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = dspb_pkg::S_LOAD;
                    end
                end
            end
            default: n_state = dspb_pkg::S_LOAD;
        endcase
    end

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dspb_pkg::S_DRAIN && i_status.empty) |=> r_state == dspb_pkg::S_LOAD)
        else $error("drain with empty stacks did not return to load");

    a_no_push_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dspb_pkg::S_DRAIN |-> !o_cmd.push)
        else $error("push issued during drain");

    a_step_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> busy && !i_status.empty)
        else $error("drain step without stored values");

endmodule

>>> hdl/dspb_dp.sv
module dspb_dp #(
    parameter int STORE_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dspb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dspb_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic signed [dspb_pkg::DATA_W-1:0]   i_value,
    input  dspb_pkg::t_cmd                       i_cmd,
    output dspb_pkg::t_status                    o_status,
    output logic                                 o_strobe,
    output logic signed [dspb_pkg::DATA_W-1:0]   o_out_value,
    output logic                                 o_from_high_stack,
    output logic                                 o_last_of_run
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int RST_UC = (STORE_DEPTH < dspb_pkg::RST_CAP) ? STORE_DEPTH
                                                               : dspb_pkg::RST_CAP;
    localparam logic [dspb_pkg::CNT_W:0] DEPTH_C = (dspb_pkg::CNT_W + 1)'(STORE_DEPTH);

    logic [dspb_pkg::DATA_W-1:0]   r_mem [STORE_DEPTH];
    logic [dspb_pkg::CNT_W-1:0]    r_uc;
    logic [dspb_pkg::CNT_W-1:0]    n_uc;
    logic [dspb_pkg::LIMIT_W-1:0]  r_limit;
    logic [dspb_pkg::CNT_W-1:0]    r_low_top;
    logic [dspb_pkg::CNT_W-1:0]    n_low_top;
    logic [dspb_pkg::CNT_W-1:0]    r_high_top;
    logic [dspb_pkg::CNT_W-1:0]    n_high_top;
    logic [dspb_pkg::CNT_W-1:0]    uc_m1;
    logic [dspb_pkg::CNT_W-1:0]    high_p1;
    logic [dspb_pkg::CNT_W-1:0]    rd_ptr;
    logic [dspb_pkg::CNT_W-1:0]    wr_ptr;
    logic [dspb_pkg::CNT_W:0]      cap_req;
    logic                          is_low;
    logic                          rd_high;
    logic                          r_strobe;
    logic [dspb_pkg::DATA_W-1:0]   r_rd_data;
    logic                          r_from_high;
    logic                          r_last;

    assign uc_m1   = r_uc - 1'b1;
    assign high_p1 = r_high_top + 1'b1;
    assign is_low  = $unsigned(i_value) < {1'b0, r_limit};
    assign wr_ptr  = is_low ? r_low_top : r_high_top;
    assign rd_high = (r_low_top == '0);
    assign rd_ptr  = rd_high ? high_p1 : r_low_top - 1'b1;
    assign cap_req = {1'b0, i_cfg_wdata[dspb_pkg::CNT_W-1:0]};

    always_comb begin
        o_status.end_mark    = ($unsigned(i_value) == dspb_pkg::END_MARK);
        o_status.met         = (r_high_top <= r_low_top);
        o_status.meets_after = (r_high_top == r_low_top + 1'b1);
        o_status.empty       = (r_low_top == '0) && (r_high_top == uc_m1);
        o_status.last        = ((r_low_top == dspb_pkg::CNT_W'(1)) && (r_high_top == uc_m1))
                            || ((r_low_top == '0) && (high_p1 == uc_m1));
    end

    always_comb begin
        priority if (cap_req == '0) begin
            n_uc = dspb_pkg::CNT_W'(1);
        end else if (cap_req > DEPTH_C) begin
            n_uc = dspb_pkg::CNT_W'(STORE_DEPTH);
        end else begin
            n_uc = cap_req[dspb_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        n_low_top  = r_low_top;
        n_high_top = r_high_top;
        priority if (i_cfg_we && i_cfg_idx == dspb_pkg::REG_USED_CAPACITY) begin
            n_low_top  = '0;
            n_high_top = n_uc - 1'b1;
        end else if (i_cmd.push) begin
            if (is_low) begin
                n_low_top = r_low_top + 1'b1;
            end else begin
                n_high_top = r_high_top - 1'b1;
            end
        end else if (i_cmd.step) begin
            if (rd_high) begin
                n_high_top = high_p1;
            end else begin
                n_low_top = r_low_top - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uc       <= dspb_pkg::CNT_W'(RST_UC);
            r_limit    <= dspb_pkg::RST_LIMIT;
            r_low_top  <= '0;
            r_high_top <= dspb_pkg::CNT_W'(RST_UC - 1);
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == dspb_pkg::REG_USED_CAPACITY) begin
                r_uc <= n_uc;
            end
            if (i_cfg_we && i_cfg_idx == dspb_pkg::REG_SMALL_LIMIT) begin
                r_limit <= i_cfg_wdata;
            end
            r_low_top  <= n_low_top;
            r_high_top <= n_high_top;
            r_strobe   <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_ptr[AW-1:0]] <= i_value;
        end
        if (i_cmd.step) begin
            r_rd_data   <= r_mem[rd_ptr[AW-1:0]];
            r_from_high <= rd_high;
            r_last      <= o_status.last;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_out_value       = r_rd_data;
    assign o_from_high_stack = r_from_high;
    assign o_last_of_run     = r_strobe && r_last;

    a_tops_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_top <= r_high_top)
        else $error("low top passed high top");

    a_high_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_top < r_uc)
        else $error("high top outside used capacity");

    a_strobe_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_strobe)
        else $error("drain step produced no transfer");

endmodule

>>> hdl/dual_stack_partition_buffer.sv
// Two stacks share one store: small non-negative values (below small_limit) go on the low
// stack, all others on the high stack. An item is taken when start is high and busy is low.
// The value -1, or a push that makes the two tops meet, ends the load: busy then stays high,
// also if nothing is stored, while the single read port of the store is walked, low stack
// newest first, then high stack newest first. Each result is shown for one cycle under
// o_strobe, in the cycle after its read, and is not held; o_last_of_run marks the final one.
// Write used_capacity or small_limit only while busy is low and no result is pending;
// writing used_capacity empties both stacks.
module dual_stack_partition_buffer #(
    parameter int STORE_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [dspb_pkg::DATA_W-1:0] i_value,
    input  logic                               i_cfg_we,
    input  logic [dspb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dspb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                               o_strobe,
    output logic signed [dspb_pkg::DATA_W-1:0] o_out_value,
    output logic                               o_from_high_stack,
    output logic                               o_last_of_run
);

    dspb_pkg::t_cmd    cmd;
    dspb_pkg::t_status status;

    dspb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dspb_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_value           (i_value),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_strobe          (o_strobe),
        .o_out_value       (o_out_value),
        .o_from_high_stack (o_from_high_stack),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

>>> test/tb_dual_stack_partition_buffer.sv
`timescale 1ns / 100ps

module tb_dual_stack_partition_buffer;

    localparam int STORE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [dspb_pkg::DATA_W-1:0] value;
        logic                        high;
        logic                        last;
    } t_drained;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [dspb_pkg::DATA_W-1:0]     i_value;
    logic                                   i_cfg_we;
    logic [dspb_pkg::CFG_IDX_W-1:0]         i_cfg_idx;
    logic [dspb_pkg::CFG_DATA_W-1:0]        i_cfg_wdata;
    logic                                   o_strobe;
    logic signed [dspb_pkg::DATA_W-1:0]     o_out_value;
    logic                                   o_from_high_stack;
    logic                                   o_last_of_run;

    logic [dspb_pkg::DATA_W-1:0]  stack_mem [STORE_DEPTH];
    int unsigned                  low_count;
    int unsigned                  high_free;
    int unsigned                  capacity_m;
    logic [dspb_pkg::LIMIT_W-1:0] limit_m;

    t_drained drained_q [$];
    int       err_count;
    int       cycle_count;
    int       idle_pct;

    dual_stack_partition_buffer #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_value          (i_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_out_value      (o_out_value),
        .o_from_high_stack(o_from_high_stack),
        .o_last_of_run    (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_stacks();
        low_count = 0;
        high_free = capacity_m - 1;
    endfunction

    function automatic void unload_stacks();
        int n = 0;
        for (int i = low_count; i > 0; i--) begin
            drained_q.push_back('{stack_mem[i-1], 1'b0, 1'b0});
            n++;
        end
        for (int i = high_free + 1; i < capacity_m; i++) begin
            drained_q.push_back('{stack_mem[i], 1'b1, 1'b0});
            n++;
        end
        if (n > 0)
            drained_q[drained_q.size()-1].last = 1'b1;
        clear_stacks();
    endfunction

    function automatic void predict_transfer(input logic [dspb_pkg::DATA_W-1:0] v);
        if (high_free <= low_count || v == dspb_pkg::END_MARK) begin
            unload_stacks();
            return;
        end
        if (v < {1'b0, limit_m}) begin
            stack_mem[low_count] = v;
            low_count++;
        end else begin
            stack_mem[high_free] = v;
            high_free--;
        end
        if (high_free <= low_count)
            unload_stacks();
    endfunction

    function automatic void predict_config(input logic [dspb_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [dspb_pkg::CFG_DATA_W-1:0] data);
        int unsigned c;
        if (idx == dspb_pkg::REG_USED_CAPACITY) begin
            c = data[dspb_pkg::CNT_W-1:0];
            if (c == 0)
                c = 1;
            if (c > STORE_DEPTH)
                c = STORE_DEPTH;
            capacity_m = c;
            clear_stacks();
        end else begin
            limit_m = data[dspb_pkg::LIMIT_W-1:0];
        end
    endfunction

    function automatic logic [dspb_pkg::DATA_W-1:0] pick_value();
        logic [dspb_pkg::DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(15, 0))
            0, 1, 2, 3, 4, 5: begin
                if (limit_m != 0)
                    r = $urandom_range(limit_m - 1, 0);
            end
            6, 7:    r = {1'b1, r[dspb_pkg::DATA_W-2:0]};
            8:       r = {1'b0, limit_m};
            9:       r = {1'b0, limit_m} - 1;
            10:      r = ($urandom_range(1, 0) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            11:      r = ($urandom_range(7, 0) == 0) ? dspb_pkg::END_MARK : 32'hFFFF_FFFE;
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_value(input logic [dspb_pkg::DATA_W-1:0] v);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_transfer(v);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (drained_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dspb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dspb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        predict_config(idx, data);
    endtask

    task automatic random_config();
        logic [dspb_pkg::CFG_DATA_W-1:0] d;
        d = dspb_pkg::CFG_DATA_W'($urandom);
        case ($urandom_range(9, 0))
            0:       d[dspb_pkg::CNT_W-1:0] = 6'd1;
            1:       d[dspb_pkg::CNT_W-1:0] = 6'd32;
            2:       d[dspb_pkg::CNT_W-1:0] = ($urandom_range(1, 0) != 0) ? 6'd0 : 6'd63;
            default: d[dspb_pkg::CNT_W-1:0] = dspb_pkg::CNT_W'($urandom_range(8, 2));
        endcase
        write_reg(dspb_pkg::REG_USED_CAPACITY, d);
        case ($urandom_range(4, 0))
            0:       d = '0;
            1:       d = 31'h7FFF_FFFF;
            2:       d = dspb_pkg::RST_LIMIT;
            3:       d = dspb_pkg::CFG_DATA_W'($urandom_range(64, 1));
            default: d = dspb_pkg::CFG_DATA_W'($urandom);
        endcase
        write_reg(dspb_pkg::REG_SMALL_LIMIT, d);
    endtask

    task automatic test_default_split();
        idle_pct = 0;
        send_value(32'd0);
        send_value(32'd999);
        send_value(32'd1000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFE);
        send_value(dspb_pkg::END_MARK);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
    endtask

    task automatic test_capacity();
        write_reg(dspb_pkg::REG_USED_CAPACITY, 31'd4);
        send_value(32'd5);
        send_value(32'd2000);
        send_value(32'd7);
        wait_drained();
        write_reg(dspb_pkg::REG_USED_CAPACITY, 31'd1);
        send_value(32'd3);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
        write_reg(dspb_pkg::REG_USED_CAPACITY, 31'd0);
        send_value(32'd8);
        wait_drained();
        write_reg(dspb_pkg::REG_USED_CAPACITY, 31'd63);
        send_value(32'd1);
        send_value(32'd5000);
        wait_drained();
        write_reg(dspb_pkg::REG_USED_CAPACITY, 31'h7FFF_FFE0);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        write_reg(dspb_pkg::REG_SMALL_LIMIT, 31'd0);
        send_value(32'd0);
        send_value(32'd5);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
        write_reg(dspb_pkg::REG_SMALL_LIMIT, 31'h7FFF_FFFF);
        send_value(32'h7FFF_FFFE);
        send_value(32'h7FFF_FFFF);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
        write_reg(dspb_pkg::REG_SMALL_LIMIT, 31'd1);
        send_value(32'd0);
        send_value(32'd1);
        send_value(dspb_pkg::END_MARK);
        wait_drained();
    endtask

    task automatic test_random_loads(input int pct, input int n_items);
        int sent;
        int len;
        sent     = 0;
        idle_pct = pct;
        while (sent < n_items) begin
            if ($urandom_range(5, 0) == 0) begin
                wait_drained();
                random_config();
            end
            len = $urandom_range(capacity_m + 1, 0);
            for (int k = 0; k < len; k++) begin
                send_value(pick_value());
                sent++;
            end
            if ($urandom_range(3, 0) != 0) begin
                send_value(dspb_pkg::END_MARK);
                sent++;
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n && o_strobe) begin
            if (drained_q.size() == 0) begin
                err_count <= err_count + 1;
                $display("%0t unexpected transfer: expected none, actual %h",
                         $time, o_out_value);
            end else begin
                if (o_out_value !== drained_q[0].value ||
                    o_from_high_stack !== drained_q[0].high ||
                    o_last_of_run !== drained_q[0].last) begin
                    err_count <= err_count + 1;
                    $display("%0t mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                             drained_q[0].value, drained_q[0].high, drained_q[0].last,
                             o_out_value, o_from_high_stack, o_last_of_run);
                end
                void'(drained_q.pop_front());
            end
        end
    end

    initial begin
        err_count   = 0;
        cycle_count = 0;
        idle_pct    = 0;
        capacity_m  = dspb_pkg::RST_CAP;
        limit_m     = dspb_pkg::RST_LIMIT;
        clear_stacks();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_value     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= dspb_pkg::REG_USED_CAPACITY;
        i_cfg_wdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_split();
        test_capacity();
        test_limit_extremes();
        test_random_loads(29, 170);
        test_random_loads(71, 170);
        test_random_loads(0, 170);

        if (err_count == 0 && drained_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
